// File: hdl/spfb_pkg.sv
// ----------------------------------------------------------------------------
// spfb_pkg: shared types and constants of the status panel frame builder
// Segment codes, register indexes, frame layout and the frame record
// passed from the converter to the serializer.
// ----------------------------------------------------------------------------
package spfb_pkg;

	localparam int NUM_POSITIONS = 8;
	localparam int VALUE_CHARS   = 5;
	localparam int FRAME_BYTES   = 2 + 2 * NUM_POSITIONS;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CNT_W  = $clog2(VALUE_CHARS + 1);
	localparam int BIDX_W = $clog2(FRAME_BYTES);
	localparam int POS_W  = $clog2(NUM_POSITIONS);

	localparam logic [7:0] SEG_C     = 8'h39;
	localparam logic [7:0] SEG_MINUS = 8'h40;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	localparam logic [7:0] WRITE_AUTO_RESET = 8'h40;
	localparam logic [7:0] START_ADDR_RESET = 8'hC0;

	// reciprocal of ten, exact for every 16-bit dividend with a shift of 19
	localparam logic [15:0] RECIP_TEN = 16'hCCCD;
	localparam int          RECIP_SH  = 19;

	typedef enum logic [7:0] {
		REG_WRITE_AUTO = 8'd0,
		REG_START_ADDR = 8'd1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]                        client_seg;
		logic [VALUE_CHARS-1:0][7:0]       vel_seg;
		logic                              led_link;
		logic                              estop;
		logic                              send;
		logic [7:0]                        keys;
	} frame_t;

	function automatic logic [7:0] seg_digit(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/spfb_in_if.sv
// ----------------------------------------------------------------------------
// spfb_in_if: tick channel
// One word per refresh tick: key scan bytes, client count, velocity, link.
// ----------------------------------------------------------------------------
interface spfb_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         scan_byte_a;
	logic [7:0]         scan_byte_b;
	logic [7:0]         scan_byte_c;
	logic [7:0]         scan_byte_d;
	logic [7:0]         client_num;
	logic signed [15:0] velocity;
	logic               link_ok;

	modport source (
		output valid, scan_byte_a, scan_byte_b, scan_byte_c, scan_byte_d,
		output client_num, velocity, link_ok,
		input  ready
	);
	modport sink (
		input  valid, scan_byte_a, scan_byte_b, scan_byte_c, scan_byte_d,
		input  client_num, velocity, link_ok,
		output ready
	);
endinterface

// File: hdl/spfb_out_if.sv
// ----------------------------------------------------------------------------
// spfb_out_if: byte channel
// One word per byte sent to the panel driver, with frame marks and status.
// ----------------------------------------------------------------------------
interface spfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       frame_first;
	logic       last;
	logic       estop_state;
	logic       send_now;
	logic [7:0] key_map;

	modport source (
		output valid, byte_out, frame_first, last, estop_state, send_now, key_map,
		input  ready
	);
	modport sink (
		input  valid, byte_out, frame_first, last, estop_state, send_now, key_map,
		output ready
	);
endinterface

// File: hdl/spfb_cfg_if.sv
// ----------------------------------------------------------------------------
// spfb_cfg_if: register write channel
// One word per register write: register index and write data.
// ----------------------------------------------------------------------------
interface spfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: hdl/spfb_front.sv
// ----------------------------------------------------------------------------
// spfb_front: tick intake and frame converter
// Hold one tick, update the stop flag, convert the velocity one digit a cycle.
// ----------------------------------------------------------------------------
module spfb_front
	import spfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	spfb_in_if.sink     item,
	output logic        push,
	output frame_t      push_frame,
	input  logic        full
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIGIT = 3'b010,
		ST_PUSH  = 3'b100
	} state_t;

	state_t state_q;

	logic               valid_s1;
	logic [7:0]         keys_s1;
	logic [7:0]         client_s1;
	logic [15:0]        vel_s1;
	logic               link_s1;

	logic               prev_key_one_q;
	logic               estop_q;

	frame_t             frame_q;
	logic [15:0]        mag_q;
	logic               neg_q;
	logic [CNT_W-1:0]   n_q;

	logic               start;
	logic               key_one;
	logic               toggle;
	logic               estop_next;
	logic [31:0]        prod;
	logic [15:0]        quot;
	logic [15:0]        rem;
	logic [CNT_W-1:0]   n_next;
	logic               last_digit;
	logic [7:0]         keys_in;
	logic [15:0]        vel_mag;

	assign push       = (state_q == ST_PUSH) && !full;
	assign push_frame = frame_q;

	// a new conversion starts when the converter is free or frees up now
	assign start      = valid_s1 && ((state_q == ST_IDLE) || push);
	assign item.ready = !valid_s1 || start;

	assign keys_in = {item.scan_byte_d[4], item.scan_byte_c[4],
	                  item.scan_byte_b[4], item.scan_byte_a[4],
	                  item.scan_byte_d[0], item.scan_byte_c[0],
	                  item.scan_byte_b[0], item.scan_byte_a[0]};

	assign key_one    = keys_s1[0];
	assign toggle     = key_one && !prev_key_one_q;
	assign estop_next = estop_q ^ toggle;
	assign vel_mag    = vel_s1[15] ? (~vel_s1 + 16'd1) : vel_s1;

	assign prod       = mag_q * RECIP_TEN;
	assign quot       = 16'(prod >> RECIP_SH);
	assign rem        = mag_q - ((quot << 3) + (quot << 1));
	assign n_next     = n_q + CNT_W'(1);
	assign last_digit = (quot == 16'd0) || (n_next == CNT_W'(VALUE_CHARS));

	// hold register for the next tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (start) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			keys_s1   <= keys_in;
			client_s1 <= item.client_num;
			vel_s1    <= item.velocity;
			link_s1   <= item.link_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_key_one_q <= 1'b0;
			estop_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (last_digit) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (start) begin
						state_q <= ST_DIGIT;
					end else if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (start) begin
				prev_key_one_q <= key_one;
				estop_q        <= estop_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			frame_q.client_seg <= seg_digit((client_s1 > 8'd9) ? 4'd9 : client_s1[3:0]);
			frame_q.vel_seg    <= '0;
			frame_q.led_link   <= !link_s1;
			frame_q.estop      <= estop_next;
			frame_q.send       <= toggle && estop_next;
			frame_q.keys       <= keys_s1;
			mag_q              <= vel_mag;
			neg_q              <= vel_s1[15];
			n_q                <= '0;
		end else if (state_q == ST_DIGIT) begin
			// fill from the right; a minus goes left of the last digit if it fits
			for (int c = 0; c < VALUE_CHARS; c++) begin
				if (CNT_W'(c) == CNT_W'(VALUE_CHARS - 1) - n_q) begin
					frame_q.vel_seg[c] <= seg_digit(rem[3:0]);
				end
				if (last_digit && neg_q && (n_next != CNT_W'(VALUE_CHARS)) &&
				    (CNT_W'(c) == CNT_W'(VALUE_CHARS - 1) - n_next)) begin
					frame_q.vel_seg[c] <= SEG_MINUS;
				end
			end
			mag_q <= quot;
			n_q   <= n_next;
		end
	end

endmodule

// File: hdl/spfb_queue.sv
// ----------------------------------------------------------------------------
// spfb_queue: frame queue
// Short first-in first-out store of converted frames.
// ----------------------------------------------------------------------------
module spfb_queue
	import spfb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output frame_t pop_frame,
	output logic   not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: hdl/spfb_back.sv
// ----------------------------------------------------------------------------
// spfb_back: byte serializer
// Walk one frame out as eighteen words through an output register.
// ----------------------------------------------------------------------------
module spfb_back
	import spfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  write_auto,
	input  logic [7:0]  start_addr,
	input  logic        not_empty,
	input  frame_t      pop_frame,
	output logic        pop,
	spfb_out_if.source  result
);

	frame_t              cur_q;
	logic                busy_q;
	logic [BIDX_W-1:0]   idx_q;

	logic                out_valid_q;
	logic [7:0]          byte_q;
	logic                first_q;
	logic                last_q;
	logic                estop_q;
	logic                send_q;
	logic [7:0]          keys_q;

	logic                load;
	logic                finishing;
	logic [BIDX_W-1:0]   rel;
	logic [POS_W-1:0]    pos;
	logic [7:0]          seg_byte;
	logic [7:0]          led_byte;
	logic [7:0]          next_byte;

	assign load      = busy_q && (!out_valid_q || result.ready);
	assign finishing = load && (idx_q == BIDX_W'(FRAME_BYTES - 1));
	assign pop       = not_empty && (!busy_q || finishing);

	assign rel = idx_q - BIDX_W'(2);
	assign pos = POS_W'(rel >> 1);

	always_comb begin
		seg_byte = SEG_BLANK;
		if (pos == POS_W'(0)) begin
			seg_byte = SEG_C;
		end else if (pos == POS_W'(1)) begin
			seg_byte = cur_q.client_seg;
		end
		for (int c = 0; c < VALUE_CHARS; c++) begin
			if (pos == POS_W'(NUM_POSITIONS - VALUE_CHARS + c)) begin
				seg_byte = cur_q.vel_seg[c];
			end
		end
		led_byte = 8'd0;
		if (pos == POS_W'(0)) begin
			led_byte = {7'd0, cur_q.estop};
		end else if (pos == POS_W'(1)) begin
			led_byte = {7'd0, cur_q.led_link};
		end
		if (idx_q == BIDX_W'(0)) begin
			next_byte = write_auto;
		end else if (idx_q == BIDX_W'(1)) begin
			next_byte = start_addr;
		end else if (rel[0]) begin
			next_byte = led_byte;
		end else begin
			next_byte = seg_byte;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.byte_out    = byte_q;
	assign result.frame_first = first_q;
	assign result.last        = last_q;
	assign result.estop_state = estop_q;
	assign result.send_now    = send_q;
	assign result.key_map     = keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new frame takes over right at the last byte of the old one
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (load) begin
					idx_q <= idx_q + BIDX_W'(1);
				end
				if (finishing) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_frame;
		end
		if (load) begin
			byte_q  <= next_byte;
			first_q <= (idx_q < BIDX_W'(2));
			last_q  <= (idx_q == BIDX_W'(FRAME_BYTES - 1));
			estop_q <= cur_q.estop;
			send_q  <= cur_q.send;
			keys_q  <= cur_q.keys;
		end
	end

endmodule

// File: hdl/status_panel_frame_builder_top.sv
// ----------------------------------------------------------------------------
// status_panel_frame_builder_top: status panel frame builder
// Turn each refresh tick into the eighteen-byte command stream of a
// seven-segment/LED panel: write command, start address, eight
// segment/LED pairs showing 'C', client digit, blank and the velocity.
//
//   channel | dir | word                                   | accepted when
//   --------+-----+----------------------------------------+-------------------
//   item    | in  | scan bytes, client count, velocity,    | valid && ready
//           |     | link flag (one tick)                   |
//   result  | out | one panel byte with frame/status marks | valid && ready
//   cfg     | in  | register index and 8-bit data          | valid && ready
//
// Rate: a tick yields 18 result words at one word per cycle while
// result.ready stays high, so the output register sets the sustained rate.
// The converter takes a start step for each tick and then converts the
// velocity one digit at a time on the shared divide-by-ten step.
// Reset: arst_n clears the stop flag, the previous key level, the queue and
// all valid flags, and loads the command registers with 0x40 and 0xC0.
// Stalls: result.ready low holds the output word; the converter keeps going
// until the frame queue is full, and item.ready falls only when the hold
// register is occupied and the converter cannot take it.
// ----------------------------------------------------------------------------
module status_panel_frame_builder_top
	import spfb_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	spfb_in_if.sink    item,
	spfb_out_if.source result,
	spfb_cfg_if.sink   cfg
);

	logic [7:0] write_auto_q;
	logic [7:0] start_addr_q;

	logic       push;
	frame_t     push_frame;
	logic       full;
	logic       pop;
	frame_t     pop_frame;
	logic       not_empty;

	// register writes are always accepted
	assign cfg.ready = 1'b1;

	// decode the register index; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_auto_q <= WRITE_AUTO_RESET;
			start_addr_q <= START_ADDR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_WRITE_AUTO: write_auto_q <= cfg.data;
				REG_START_ADDR: start_addr_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// front: take ticks, update the stop flag, build the segment record
	spfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.push_frame (push_frame),
		.full       (full)
	);

	// queue: decouple conversion from the byte stream
	spfb_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (full),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.not_empty  (not_empty)
	);

	// back: advance through the frame one byte per accepted word
	spfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_auto (write_auto_q),
		.start_addr (start_addr_q),
		.not_empty  (not_empty),
		.pop_frame  (pop_frame),
		.pop        (pop),
		.result     (result)
	);

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for status_panel_frame_builder_top
// Drives refresh ticks and register writes, predicts the eighteen panel bytes
// of every accepted tick in a small scoreboard, and compares each byte word
// with the oldest prediction. Runs under several idle/stall mixes, with a
// long receiver hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module tb
	import spfb_pkg::*;
;

	// one predicted byte word of the panel stream
	typedef struct packed {
		logic [7:0] data;
		logic       frame_first;
		logic       last;
		logic       estop;
		logic       send;
		logic [7:0] keys;
	} panel_word_t;

	// Predicts the panel stream from the accepted ticks and checks the
	// byte words against it, oldest first.
	class panel_frame_predictor;
		logic [7:0]  write_auto_cmd;
		logic [7:0]  start_addr_cmd;
		logic        prev_key_one;
		logic        estop_on;
		panel_word_t expected_words[$];
		int          mismatches;

		function new();
			write_auto_cmd = WRITE_AUTO_RESET;
			start_addr_cmd = START_ADDR_RESET;
			prev_key_one   = 1'b0;
			estop_on       = 1'b0;
			mismatches     = 0;
		endfunction

		function logic [7:0] digit_glyph(int d);
			case (d)
				0: return 8'h3F;
				1: return 8'h06;
				2: return 8'h5B;
				3: return 8'h4F;
				4: return 8'h66;
				5: return 8'h6D;
				6: return 8'h7D;
				7: return 8'h07;
				8: return 8'h7F;
				default: return 8'h6F;
			endcase
		endfunction

		// unknown indexes are dropped by the block
		function void write_reg(logic [7:0] idx, logic [7:0] val);
			if (idx == REG_WRITE_AUTO) begin
				write_auto_cmd = val;
			end else if (idx == REG_START_ADDR) begin
				start_addr_cmd = val;
			end
		endfunction

		function void note_tick(logic [7:0] sa, logic [7:0] sb, logic [7:0] sc,
				logic [7:0] sd, logic [7:0] cc, logic [15:0] vel, logic link);
			logic [7:0]  keys;
			logic [7:0]  seg [NUM_POSITIONS];
			logic [7:0]  frame [FRAME_BYTES];
			logic        send;
			int          mag;
			int          n;
			int          p;
			panel_word_t w;
			keys = {sd[4], sc[4], sb[4], sa[4], sd[0], sc[0], sb[0], sa[0]};
			send = 1'b0;
			if (keys[0] && !prev_key_one) begin
				estop_on = !estop_on;
				send     = estop_on;
			end
			prev_key_one = keys[0];
			seg[0] = SEG_C;
			seg[1] = digit_glyph((cc > 9) ? 9 : int'(cc));
			for (p = 2; p < NUM_POSITIONS; p++) begin
				seg[p] = SEG_BLANK;
			end
			// right-justify the magnitude; a five-digit negative has no room
			// left for its minus sign
			mag = vel[15] ? 65536 - int'(vel) : int'(vel);
			n = 0;
			do begin
				seg[NUM_POSITIONS - 1 - n] = digit_glyph(mag % 10);
				mag = mag / 10;
				n++;
			end while (mag != 0 && n < VALUE_CHARS);
			if (vel[15] && n < VALUE_CHARS) begin
				seg[NUM_POSITIONS - 1 - n] = SEG_MINUS;
			end
			frame[0] = write_auto_cmd;
			frame[1] = start_addr_cmd;
			for (p = 0; p < NUM_POSITIONS; p++) begin
				frame[2 + 2 * p] = seg[p];
				frame[3 + 2 * p] = (p == 0) ? {7'd0, estop_on} :
				                   (p == 1) ? {7'd0, !link} : 8'h00;
			end
			for (p = 0; p < FRAME_BYTES; p++) begin
				w.data        = frame[p];
				w.frame_first = (p < 2);
				w.last        = (p == FRAME_BYTES - 1);
				w.estop       = estop_on;
				w.send        = send;
				w.keys        = keys;
				expected_words.push_back(w);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void check_field(string name, logic [7:0] exp, logic [7:0] act);
			if (act !== exp) begin
				$error("%s: expected 0x%02h, got 0x%02h", name, exp, act);
				mismatches++;
			end
		endfunction

		function void check_word(panel_word_t got);
			panel_word_t exp;
			if (expected_words.size() == 0) begin
				$error("byte word 0x%02h arrived with no byte pending", got.data);
				mismatches++;
				return;
			end
			exp = expected_words.pop_front();
			check_field("byte_out", exp.data, got.data);
			check_field("frame_first", 8'(exp.frame_first), 8'(got.frame_first));
			check_field("last", 8'(exp.last), 8'(got.last));
			check_field("estop_state", 8'(exp.estop), 8'(got.estop));
			check_field("send_now", 8'(exp.send), 8'(got.send));
			check_field("key_map", exp.keys, got.keys);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spfb_in_if  tick_ch ();
	spfb_out_if byte_ch ();
	spfb_cfg_if reg_ch ();

	status_panel_frame_builder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (tick_ch),
		.result (byte_ch),
		.cfg    (reg_ch)
	);

	panel_frame_predictor panel = new();

	// idle mix of the current phase, in percent of cycles
	int send_idle_pct;
	int recv_stall_pct;
	// cycles the receiver still has to hold off; counted down by the receiver
	int hold_off_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watch all three channels at the rising edge. Results are checked
	// before the tick of the same edge is noted: a tick accepted now cannot
	// have produced a byte yet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				panel.check_word(panel_word_t'({byte_ch.byte_out, byte_ch.frame_first,
					byte_ch.last, byte_ch.estop_state, byte_ch.send_now,
					byte_ch.key_map}));
			end
			if (tick_ch.valid && tick_ch.ready) begin
				panel.note_tick(tick_ch.scan_byte_a, tick_ch.scan_byte_b,
					tick_ch.scan_byte_c, tick_ch.scan_byte_d, tick_ch.client_num,
					tick_ch.velocity, tick_ch.link_ok);
			end
			if (reg_ch.valid && reg_ch.ready) begin
				panel.write_reg(reg_ch.index, reg_ch.data);
			end
		end
	end

	// Receiver: a pending hold-off wins over the random stall mix.
	initial begin
		byte_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				byte_ch.ready <= 1'b0;
				hold_off_left--;
			end else begin
				byte_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one tick, after a random gap; return at the falling edge after
	// the handshake with valid still high so back-to-back ticks stay dense.
	task automatic send_tick(input logic [7:0] sa, input logic [7:0] sb,
			input logic [7:0] sc, input logic [7:0] sd, input logic [7:0] cc,
			input logic [15:0] vel, input logic link);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid        <= 1'b1;
		tick_ch.scan_byte_a  <= sa;
		tick_ch.scan_byte_b  <= sb;
		tick_ch.scan_byte_c  <= sc;
		tick_ch.scan_byte_d  <= sd;
		tick_ch.client_num   <= cc;
		tick_ch.velocity     <= vel;
		tick_ch.link_ok      <= link;
		do @(posedge clk); while (!tick_ch.ready);
		@(negedge clk);
	endtask

	// Random tick with the velocity steered toward the digit-count edges.
	task automatic rand_tick();
		int         v;
		logic [7:0] cc;
		case ($urandom_range(3))
			0: v = $urandom_range(65535);
			1: v = int'($urandom_range(240)) - 120;
			2: v = $urandom_range(1) ? -int'($urandom_range(10010, 9990))
			                         : int'($urandom_range(10010, 9990));
			default: v = $urandom_range(1) ? -int'($urandom_range(32768, 10000))
			                               : int'($urandom_range(32767, 10000));
		endcase
		cc = $urandom_range(1) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
		send_tick(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), cc, v[15:0],
			1'($urandom_range(1)));
	endtask

	// Drop valid and hold until every predicted byte has come out.
	task automatic drain();
		tick_ch.valid <= 1'b0;
		do @(negedge clk); while (panel.pending() != 0);
	endtask

	// One register write; valid is dropped again before the task returns.
	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= val;
		do @(posedge clk); while (!reg_ch.ready);
		@(negedge clk);
		reg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_unknown_reg();
		write_reg(8'($urandom_range(255, REG_START_ADDR + 1)), 8'($urandom_range(255)));
	endtask

	task automatic run_phase(input int idle, input int stall, input int count);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (count) rand_tick();
	endtask

	initial begin
		arst_n               = 1'b0;
		tick_ch.valid        = 1'b0;
		tick_ch.scan_byte_a  = 8'h00;
		tick_ch.scan_byte_b  = 8'h00;
		tick_ch.scan_byte_c  = 8'h00;
		tick_ch.scan_byte_d  = 8'h00;
		tick_ch.client_num   = 8'h00;
		tick_ch.velocity     = 16'sd0;
		tick_ch.link_ok      = 1'b0;
		reg_ch.valid         = 1'b0;
		reg_ch.index         = REG_WRITE_AUTO;
		reg_ch.data          = 8'h00;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		hold_off_left        = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks under the reset command bytes: key 1 edges that
		// toggle the stop flag both ways, held and released keys, ignored
		// scan bits, client saturation and the velocity corner values.
		send_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 16'sd0, 1'b1);
		send_tick(8'h01, 8'h00, 8'h00, 8'h00, 8'd9, 16'sd32767, 1'b0);
		send_tick(8'h01, 8'h00, 8'h00, 8'h00, 8'd10, -16'sd32768, 1'b1);
		send_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'd255, -16'sd10000, 1'b1);
		send_tick(8'h01, 8'h00, 8'h00, 8'h00, 8'd1, -16'sd9999, 1'b0);
		send_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd2, -16'sd1, 1'b1);
		send_tick(8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'd3, 16'sd10000, 1'b1);
		send_tick(8'h10, 8'h01, 8'h10, 8'h01, 8'd4, 16'sd9, 1'b0);
		send_tick(8'h11, 8'h10, 8'h01, 8'h10, 8'd5, -16'sd10, 1'b1);
		send_tick(8'h00, 8'h11, 8'h11, 8'h11, 8'd6, 16'sd1234, 1'b1);
		send_tick(8'h01, 8'h00, 8'h00, 8'h00, 8'd7, -16'sd1234, 1'b0);
		send_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 16'sd9999, 1'b1);
		send_tick(8'hFE, 8'hEF, 8'hFE, 8'hEF, 8'd11, -16'sd100, 1'b0);
		send_tick(8'h01, 8'hFF, 8'h00, 8'hFF, 8'd128, 16'sd100, 1'b1);
		send_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'd0, -16'sd9, 1'b1);
		send_tick(8'h01, 8'h00, 8'h00, 8'h00, 8'd9, 16'sd10, 1'b0);
		drain();

		// Register extremes, with an unknown index that must be dropped.
		write_reg(REG_WRITE_AUTO, 8'h00);
		write_reg(REG_START_ADDR, 8'hFF);
		write_unknown_reg();
		run_phase(0, 0, 80);
		drain();

		write_reg(REG_WRITE_AUTO, 8'hFF);
		write_reg(REG_START_ADDR, 8'h00);
		write_unknown_reg();
		run_phase(64, 0, 80);
		drain();

		write_reg(REG_WRITE_AUTO, 8'($urandom_range(255)));
		write_reg(REG_START_ADDR, 8'($urandom_range(255)));
		write_unknown_reg();
		run_phase(0, 64, 80);
		drain();

		// Long receiver hold-off with a dense sender: fill the frame queue
		// and stall the tick input, then pause until everything is out.
		write_reg(REG_WRITE_AUTO, WRITE_AUTO_RESET);
		write_reg(REG_START_ADDR, 8'($urandom_range(255)));
		write_unknown_reg();
		hold_off_left = 400;
		run_phase(0, 0, 20);
		drain();
		run_phase(6, 6, 55);

		// Drop valid, wait out the tail, and keep the clock running afterwards so
		// a stray extra byte would still be caught.
		drain();
		repeat (40) @(negedge clk);
		if (panel.mismatches == 0) begin
			$display("status_panel_frame_builder_top verification clean");
		end else begin
			$display("status_panel_frame_builder_top verification failed");
		end
		$finish;
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("status_panel_frame_builder_top verification failed");
		$finish;
	end

endmodule
